// File: rtl/mct_pkg.sv
// shared types, constants and arithmetic helpers for the macd crossover trader
`default_nettype none

package mct_pkg;

    localparam int PRICE_W   = 32;
    localparam int ALPHA_W   = 16;
    localparam int LIMIT_W   = 16;
    localparam int POS_W     = 17;
    localparam int CASH_W    = 64;
    localparam int EMA_W     = 56;
    localparam int MAG_W     = 50;
    localparam int PROD_W    = MAG_W + ALPHA_W;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_BITS  = ACT_W + POS_W + CASH_W + EMA_W + EMA_W + CASH_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // trade codes
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SELL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHORT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIGNAL = 2'd3;

    localparam logic [LIMIT_W-1:0] RST_POS_LIMIT    = 16'd5;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_LONG   = 16'd4855;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_SHORT  = 16'd10082;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_SIGNAL = 16'd13107;

    localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
    localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               first;
    } item_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] position_limit;
        logic [ALPHA_W-1:0] alpha_long;
        logic [ALPHA_W-1:0] alpha_short;
        logic [ALPHA_W-1:0] alpha_signal;
    } cfg_t;

    // magnitude of an ema difference, always below 2^49
    function automatic logic [MAG_W-1:0] ema_mag(input logic signed [EMA_W-1:0] d);
        logic signed [EMA_W-1:0] m;
        m = d[EMA_W-1] ? -d : d;
        return m[MAG_W-1:0];
    endfunction

    function automatic logic signed [CASH_W-1:0] sat_add(
        input logic signed [CASH_W-1:0] a,
        input logic signed [CASH_W-1:0] b
    );
        logic signed [CASH_W:0] s;
        s = {a[CASH_W-1], a} + {b[CASH_W-1], b};
        if (s[CASH_W] != s[CASH_W-1])
            return s[CASH_W] ? CASH_MIN : CASH_MAX;
        else
            return s[CASH_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/mct_front.sv
// front end: takes price beats, tags the seeding sample, two-entry queue to the back end
`default_nettype none

module mct_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [mct_pkg::PRICE_W-1:0]  s_tdata,   // [31:0] price
    output logic                              q_valid,
    output mct_pkg::item_t                    q_item,
    input  wire logic                         q_pop
);

    mct_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           seeded_reg, seeded_next;
    logic           push;
    logic           pop;
    mct_pkg::item_t push_item;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = q_pop && q_valid;

    always_comb
    begin
        push_item.price = s_tdata;
        push_item.first = !seeded_reg;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        seeded_next = seeded_reg || push;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            seeded_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            seeded_reg <= seeded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// File: rtl/mct_back.sv
// back end: ema sequencer on one shared multiplier, trade decision and output register
`default_nettype none

module mct_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mct_pkg::cfg_t                    cfg,
    input  wire logic                             q_valid,
    input  wire mct_pkg::item_t                   q_item,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [mct_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LONG  = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_MACD  = 3'd3;
    localparam logic [2:0] ST_SIGM  = 3'd4;
    localparam logic [2:0] ST_SIGA  = 3'd5;
    localparam logic [2:0] ST_TRADE = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam int EW = mct_pkg::EMA_W;
    localparam int CW = mct_pkg::CASH_W;
    localparam int PW = mct_pkg::POS_W;

    logic [2:0]                          state_reg, state_next;
    logic [mct_pkg::PRICE_W-1:0]         price_reg, price_next;
    logic                                first_reg, first_next;
    logic signed [EW-1:0]                long_reg, long_next;
    logic signed [EW-1:0]                short_reg, short_next;
    logic signed [EW-1:0]                sig_reg, sig_next;
    logic signed [EW-1:0]                macd_reg, macd_next;
    logic signed [PW-1:0]                held_reg, held_next;
    logic signed [CW-1:0]                cash_reg, cash_next;
    logic [mct_pkg::PROD_W-1:0]          prod_reg, prod_next;
    logic                                neg_reg, neg_next;
    logic [mct_pkg::ACT_W-1:0]           act_reg, act_next;
    logic signed [CW-1:0]                pv_reg, pv_next;
    logic                                out_valid_reg, out_valid_next;
    logic [mct_pkg::OUT_TDATA_W-1:0]     out_data_reg, out_data_next;

    logic signed [EW-1:0]                px;
    logic signed [EW-1:0]                q_ext;
    logic signed [EW-1:0]                diff;
    logic signed [EW-1:0]                short_new;
    logic [mct_pkg::MAG_W-1:0]           mul_a;
    logic [mct_pkg::ALPHA_W-1:0]         mul_b;
    logic signed [PW-1:0]                held_abs;
    logic signed [PW:0]                  held_w;
    logic signed [PW:0]                  lim_pos;
    logic                                trade_buy;
    logic                                trade_sell;
    logic signed [CW-1:0]                price_s;
    logic signed [CW-1:0]                prod_s;
    logic signed [CW-1:0]                mtm;
    logic                                out_load;

    assign px       = $signed({8'd0, price_reg, 16'd0});
    assign q_ext    = $signed({{(EW - mct_pkg::MAG_W){1'b0}},
                               prod_reg[mct_pkg::PROD_W-1:mct_pkg::ALPHA_W]});
    assign held_abs = held_reg[PW-1] ? -held_reg : held_reg;
    assign held_w   = {held_reg[PW-1], held_reg};
    assign lim_pos  = $signed({2'b00, cfg.position_limit});
    assign price_s  = $signed({{(CW - mct_pkg::PRICE_W){1'b0}}, price_reg});
    assign prod_s   = $signed({16'd0, prod_reg[47:0]});

    assign trade_buy  = (macd_reg > sig_reg) && (held_w < lim_pos);
    assign trade_sell = !trade_buy && (macd_reg < sig_reg) && (held_w > -lim_pos);

    assign mtm      = mct_pkg::sat_add(cash_reg, pv_reg);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // shared multiplier operands
    always_comb
    begin
        diff  = '0;
        mul_a = '0;
        mul_b = '0;
        neg_next = neg_reg;
        unique case (state_reg)
            ST_LONG:
            begin
                diff  = px - long_reg;
                mul_a = mct_pkg::ema_mag(diff);
                mul_b = cfg.alpha_long;
                neg_next = diff[EW-1];
            end
            ST_SHORT:
            begin
                diff  = px - short_reg;
                mul_a = mct_pkg::ema_mag(diff);
                mul_b = cfg.alpha_short;
                neg_next = diff[EW-1];
            end
            ST_SIGM:
            begin
                diff  = macd_reg - sig_reg;
                mul_a = mct_pkg::ema_mag(diff);
                mul_b = cfg.alpha_signal;
                neg_next = diff[EW-1];
            end
            ST_SIGA:
            begin
                // value of the position held before this trade
                mul_a = {{(mct_pkg::MAG_W - mct_pkg::PRICE_W){1'b0}}, price_reg};
                mul_b = held_abs[15:0];
                neg_next = held_reg[PW-1];
            end
            default:
            begin
                diff  = '0;
            end
        endcase
        prod_next = mct_pkg::PROD_W'(mul_a) * mct_pkg::PROD_W'(mul_b);
    end

    always_comb
    begin
        state_next     = state_reg;
        price_next     = price_reg;
        first_next     = first_reg;
        long_next      = long_reg;
        short_next     = short_reg;
        sig_next       = sig_reg;
        macd_next      = macd_reg;
        held_next      = held_reg;
        cash_next      = cash_reg;
        act_next       = act_reg;
        pv_next        = pv_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        short_new      = neg_reg ? short_reg - q_ext : short_reg + q_ext;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    price_next = q_item.price;
                    first_next = q_item.first;
                    state_next = ST_LONG;
                end
            end
            ST_LONG:
            begin
                state_next = ST_SHORT;
            end
            ST_SHORT:
            begin
                long_next  = first_reg ? px
                           : (neg_reg ? long_reg - q_ext : long_reg + q_ext);
                state_next = ST_MACD;
            end
            ST_MACD:
            begin
                if (first_reg)
                    short_new = px;
                short_next = short_new;
                macd_next  = short_new - long_reg;
                state_next = ST_SIGM;
            end
            ST_SIGM:
            begin
                state_next = ST_SIGA;
            end
            ST_SIGA:
            begin
                sig_next   = first_reg ? '0
                           : (neg_reg ? sig_reg - q_ext : sig_reg + q_ext);
                state_next = ST_TRADE;
            end
            ST_TRADE:
            begin
                pv_next = neg_reg ? -prod_s : prod_s;
                if (trade_buy)
                begin
                    held_next = held_reg + PW'(1);
                    cash_next = mct_pkg::sat_add(cash_reg, -price_s);
                    act_next  = mct_pkg::ACT_BUY;
                    pv_next   = (neg_reg ? -prod_s : prod_s) + price_s;
                end
                else if (trade_sell)
                begin
                    held_next = held_reg - PW'(1);
                    cash_next = mct_pkg::sat_add(cash_reg, price_s);
                    act_next  = mct_pkg::ACT_SELL;
                    pv_next   = (neg_reg ? -prod_s : prod_s) - price_s;
                end
                else
                begin
                    act_next  = mct_pkg::ACT_NONE;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_data_next  = {{(mct_pkg::OUT_TDATA_W - mct_pkg::OUT_BITS){1'b0}},
                                      mtm, sig_reg, macd_reg, cash_reg, held_reg, act_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            long_reg      <= '0;
            short_reg     <= '0;
            sig_reg       <= '0;
            held_reg      <= '0;
            cash_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            long_reg      <= long_next;
            short_reg     <= short_next;
            sig_reg       <= sig_next;
            held_reg      <= held_next;
            cash_reg      <= cash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        first_reg    <= first_next;
        macd_reg     <= macd_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        act_reg      <= act_next;
        pv_reg       <= pv_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != $signed({1'b1, {(PW-1){1'b0}}}))
        else $error("position left its range");

    a_seed_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGM && first_reg) |-> macd_reg == '0)
        else $error("seeding sample gave non-zero macd");

    a_buy_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRADE && trade_buy) |=> held_reg == $past(held_reg) + PW'(1))
        else $error("buy did not add one unit");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented after load");
`endif

endmodule

`default_nettype wire

// File: rtl/macd_crossover_trader.sv
// an accepted price beat passes the front queue, then the back end states long through out
// the back end sequencer finishes one price before it pops the next and runs the long,
// short and signal ema steps and the position value through one 50x16 multiplier
// a two-beat queue lets the front end keep taking prices while a result waits downstream
// reset (rst_n low, asynchronous): emas, position, cash and seeding flag clear,
// registers return to limit 5 and alphas 4855, 10082, 13107
`default_nettype none

module macd_crossover_trader (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mct_pkg::PRICE_W-1:0]         s_tdata,   // [31:0] price
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] action, [18:2] position, [82:19] cash_balance, [138:83] macd_value,
    // [194:139] signal_value, [258:195] mark_to_market, [263:259] zero
    output logic [mct_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mct_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mct_pkg::CFG_DAT_W-1:0]       cfg_data
);

    mct_pkg::cfg_t  cfg_reg, cfg_next;
    logic           q_valid;
    mct_pkg::item_t q_item;
    logic           q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mct_pkg::CFG_POS_LIMIT:    cfg_next.position_limit = cfg_data;
                mct_pkg::CFG_ALPHA_LONG:   cfg_next.alpha_long     = cfg_data;
                mct_pkg::CFG_ALPHA_SHORT:  cfg_next.alpha_short    = cfg_data;
                mct_pkg::CFG_ALPHA_SIGNAL: cfg_next.alpha_signal   = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_limit <= mct_pkg::RST_POS_LIMIT;
            cfg_reg.alpha_long     <= mct_pkg::RST_ALPHA_LONG;
            cfg_reg.alpha_short    <= mct_pkg::RST_ALPHA_SHORT;
            cfg_reg.alpha_signal   <= mct_pkg::RST_ALPHA_SIGNAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    mct_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking macd crossover trader testbench: directed and random prices against a predictor
`timescale 1ns / 1ps

module tb_top;

    import mct_pkg::*;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [POS_W-1:0]  position;
        logic [CASH_W-1:0] cash;
        logic [EMA_W-1:0]  macd;
        logic [EMA_W-1:0]  signal_ema;
        logic [CASH_W-1:0] mtm;
    } trade_result_t;

    typedef enum int {PX_TREND, PX_SWING, PX_NOISE} px_mode_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_CHOKE} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PRICE_W-1:0]     s_tdata = '0;      // [31:0] price
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // action, position, cash, macd, signal, mtm
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DAT_W-1:0]   cfg_data = '0;

    // pending prices and predicted result beats
    logic [PRICE_W-1:0] price_q[$];
    trade_result_t      result_q[$];

    int mismatch_count = 0;

    // predictor state and register copy
    logic [LIMIT_W-1:0] limit_cfg        = RST_POS_LIMIT;
    logic [ALPHA_W-1:0] alpha_long_cfg   = RST_ALPHA_LONG;
    logic [ALPHA_W-1:0] alpha_short_cfg  = RST_ALPHA_SHORT;
    logic [ALPHA_W-1:0] alpha_signal_cfg = RST_ALPHA_SIGNAL;
    longint est_long   = 0;
    longint est_short  = 0;
    longint est_signal = 0;
    longint units_held = 0;
    longint cash_run   = 0;
    bit     primed     = 1'b0;

    // price generator state
    longint      walk_px = 64'sd16777216;
    longint      drift_px = 64'sd256;
    int unsigned jig_span = 64;
    int          swing_len = 10;
    int          swing_left = 10;

    // sender burst state, receiver stall state
    int          burst_left = 0;
    int          gap_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [7:0]  rx_tick = '0;

    macd_crossover_trader u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < 40)
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic longint sat_sum(input longint a, input longint b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? CASH_MIN : CASH_MAX;
        return longint'(s[63:0]);
    endfunction

    // ema moves toward x by the truncated magnitude of alpha times the gap
    function automatic longint ema_move(input longint e, input longint x,
                                        input logic [ALPHA_W-1:0] a);
        longint     d;
        logic [63:0] mag;
        logic [63:0] q;
        d = x - e;
        mag = (d < 0) ? -d : d;
        q = (mag >> 16) * a + (((mag & 64'hFFFF) * a) >> 16);
        return (d < 0) ? e - longint'(q) : e + longint'(q);
    endfunction

    function automatic trade_result_t predict_trade(input logic [PRICE_W-1:0] p);
        trade_result_t r;
        longint px;
        longint pl;
        longint lim;
        longint macd;
        px  = longint'({16'd0, p, 16'd0});
        pl  = longint'({32'd0, p});
        lim = longint'({48'd0, limit_cfg});
        r.action = ACT_NONE;
        if (!primed)
        begin
            est_long = px;
            est_short = px;
            est_signal = 0;
            primed = 1'b1;
        end
        else
        begin
            est_long = ema_move(est_long, px, alpha_long_cfg);
            est_short = ema_move(est_short, px, alpha_short_cfg);
        end
        macd = est_short - est_long;
        est_signal = ema_move(est_signal, macd, alpha_signal_cfg);
        if (macd > est_signal && units_held < lim)
        begin
            units_held++;
            cash_run = sat_sum(cash_run, -pl);
            r.action = ACT_BUY;
        end
        else if (macd < est_signal && units_held > -lim)
        begin
            units_held--;
            cash_run = sat_sum(cash_run, pl);
            r.action = ACT_SELL;
        end
        r.position   = units_held[POS_W-1:0];
        r.cash       = cash_run;
        r.macd       = macd[EMA_W-1:0];
        r.signal_ema = est_signal[EMA_W-1:0];
        r.mtm        = sat_sum(cash_run, units_held * pl);
        return r;
    endfunction

    function automatic logic [PRICE_W-1:0] next_price(input px_mode_t mode);
        longint jig;
        if (mode == PX_NOISE || $urandom_range(0, 9) == 0)
            return $urandom;
        if (mode == PX_SWING)
        begin
            if (swing_left == 0)
            begin
                drift_px = -drift_px;
                swing_left = swing_len;
            end
            else
                swing_left--;
        end
        else if ($urandom_range(0, 24) == 0)
            drift_px = -drift_px;
        jig = longint'($urandom_range(0, 2 * jig_span)) - longint'(jig_span);
        walk_px = walk_px + drift_px + jig;
        // bounce off the ends of the price range
        if (walk_px < 0)
        begin
            walk_px = 0;
            drift_px = (drift_px < 0) ? -drift_px : drift_px;
        end
        else if (walk_px > 64'sd4294967295)
        begin
            walk_px = 64'sd4294967295;
            drift_px = (drift_px > 0) ? -drift_px : drift_px;
        end
        return walk_px[PRICE_W-1:0];
    endfunction

    task automatic start_walk();
        int sh;
        sh = $urandom_range(0, 20);
        if ($urandom_range(0, 2) == 0)
            walk_px = longint'({32'd0, $urandom});
        drift_px = longint'($urandom_range(1, 255)) << sh;
        if ($urandom_range(0, 1) == 0)
            drift_px = -drift_px;
        jig_span = $urandom_range(0, 255) << sh;
        swing_len = $urandom_range(6, 30);
        swing_left = swing_len;
    endtask

    task automatic queue_phase(input int n, input px_mode_t mode);
        start_walk();
        @(negedge clk);
        repeat (n) price_q = {price_q, next_price(mode)};
    endtask

    task automatic queue_price(input logic [PRICE_W-1:0] p);
        price_q = {price_q, p};
    endtask

    // block is idle once every price is taken and every result beat has come
    task automatic wait_idle();
        @(negedge clk);
        while (price_q.size() != 0 || s_tvalid || result_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // called at a rising edge, leaves cfg_valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_POS_LIMIT:    limit_cfg = v;
            CFG_ALPHA_LONG:   alpha_long_cfg = v;
            CFG_ALPHA_SHORT:  alpha_short_cfg = v;
            CFG_ALPHA_SIGNAL: alpha_signal_cfg = v;
            default:          ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] lim_v, input logic [15:0] along_v,
                              input logic [15:0] ashort_v, input logic [15:0] asig_v,
                              input logic [3:0] sel);
        @(posedge clk);
        if (sel[0]) write_reg(CFG_POS_LIMIT, lim_v);
        if (sel[1]) write_reg(CFG_ALPHA_LONG, along_v);
        if (sel[2]) write_reg(CFG_ALPHA_SHORT, ashort_v);
        if (sel[3]) write_reg(CFG_ALPHA_SIGNAL, asig_v);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 15))
            0, 1:    return 16'd0;
            2:       return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [15:0] pick_alpha();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(1000, 30000));
        endcase
    endfunction

    // sender: bursts of beats with random gaps, fed from price_q
    always @(posedge clk or negedge rst_n)
    begin : tx_side
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                result_q = {result_q, predict_trade(s_tdata)};
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (price_q.size() != 0)
                begin
                    s_tdata  <= price_q.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left <= $urandom_range(20, 60);
                            gap_left   <= 0;
                        end
                        else
                        begin
                            burst_left <= $urandom_range(1, 12);
                            gap_left   <= $urandom_range(1, 10);
                        end
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches to a random mode whenever its run ends, checks each beat
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        trade_result_t seen;
        trade_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_mode  <= RX_OPEN;
            rx_left  <= 0;
            rx_tick  <= '0;
        end
        else
        begin
            rx_tick <= rx_tick + 1'b1;
            if (rx_left == 0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(32, 256);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_QUARTER: m_tready <= (rx_tick[1:0] == 2'd0);
                default:    m_tready <= (rx_tick[3:0] < 4'd3);
            endcase

            if (m_tvalid && m_tready)
            begin
                seen.action     = m_tdata[1:0];
                seen.position   = m_tdata[18:2];
                seen.cash       = m_tdata[82:19];
                seen.macd       = m_tdata[138:83];
                seen.signal_ema = m_tdata[194:139];
                seen.mtm        = m_tdata[258:195];
                if (result_q.size() == 0)
                    flag_mismatch("beat with nothing pending", seen.mtm, '0);
                else
                begin
                    want = result_q.pop_front();
                    if (seen.action != want.action)
                        flag_mismatch("action", seen.action, want.action);
                    if (seen.position != want.position)
                        flag_mismatch("position", seen.position, want.position);
                    if (seen.cash != want.cash)
                        flag_mismatch("cash_balance", seen.cash, want.cash);
                    if (seen.macd != want.macd)
                        flag_mismatch("macd_value", seen.macd, want.macd);
                    if (seen.signal_ema != want.signal_ema)
                        flag_mismatch("signal_value", seen.signal_ema, want.signal_ema);
                    if (seen.mtm != want.mtm)
                        flag_mismatch("mark_to_market", seen.mtm, want.mtm);
                end
            end
        end
    end

    initial
    begin : stimulus
        int       pushed;
        int       n;
        int       spin;
        int       pick;
        px_mode_t mode;

        pushed = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // seeding sample, equal macd and signal, then price extremes
        queue_price(32'h0000_1000);
        queue_price(32'h0000_1000);
        queue_price(32'h0000_1000);
        queue_price(32'hFFFF_FFFF);
        queue_price(32'h0000_0000);
        queue_price(32'hFFFF_FFFF);
        queue_price(32'h8000_0000);
        queue_price(32'h7FFF_FFFF);
        queue_price(32'h5555_5555);
        queue_price(32'hAAAA_AAAA);
        wait_idle();

        // frozen long ema, widest limit
        set_config(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 4'b1111);
        queue_price(32'h0100_0000);
        queue_price(32'h0200_0000);
        queue_price(32'h0400_0000);
        queue_price(32'h0800_0000);
        queue_price(32'h1000_0000);
        wait_idle();

        // zero limit: a held position can only be unwound
        set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111);
        queue_price(32'h0800_0000);
        queue_price(32'h0400_0000);
        queue_price(32'h0200_0000);
        queue_price(32'h0100_0000);
        queue_price(32'h0080_0000);
        wait_idle();

        set_config(16'd1, RST_ALPHA_LONG, RST_ALPHA_SHORT, RST_ALPHA_SIGNAL, 4'b1111);
        queue_price(32'h0000_0001);
        queue_price(32'h00FF_FFFF);
        queue_price(32'h0000_0100);
        queue_price(32'hFFFF_FF00);
        queue_price(32'h0000_0000);
        wait_idle();

        while (pushed < 1400)
        begin
            n = $urandom_range(40, 160);
            set_config(pick_limit(), pick_alpha(), pick_alpha(), pick_alpha(),
                       4'($urandom_range(0, 15)));
            pick = $urandom_range(0, 19);
            if (pick < 10)
                mode = PX_TREND;
            else if (pick < 17)
                mode = PX_SWING;
            else
                mode = PX_NOISE;
            queue_phase(n, mode);
            pushed += n;
            wait_idle();
        end

        @(negedge clk);
        while (price_q.size() != 0 || s_tvalid)
            @(negedge clk);
        spin = 0;
        while (result_q.size() != 0 && spin < 4000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (16) @(negedge clk);
        if (result_q.size() != 0)
            flag_mismatch("results never arrived", result_q.size(), '0);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
